FILE: sv/vva_pkg.sv
`default_nettype none
package vva_pkg;

  localparam int NUM_OPS   = 12;
  localparam int OP_IDX_W  = 4;
  localparam int ISSUE_W   = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARM_FREQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUBIC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTIC   = 3'd4;

  localparam logic [30:0]        RST_INV_MASS  = 31'd65536;
  localparam logic [30:0]        RST_TIME_STEP = 31'd655;
  localparam logic signed [31:0] RST_HARM_FREQ = 32'sd65536;
  localparam logic signed [31:0] RST_CUBIC     = 32'sd0;
  localparam logic signed [31:0] RST_QUARTIC   = 32'sd0;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OPN_FRC,
    OPN_IM,
    OPN_DT,
    OPN_ACC,
    OPN_VEL,
    OPN_DV,
    OPN_W,
    OPN_POS,
    OPN_X2,
    OPN_X3,
    OPN_W2,
    OPN_C,
    OPN_G
  } opnd_t;

  typedef enum logic [3:0] {
    DST_ACC,
    DST_DV,
    DST_T1,
    DST_XN,
    DST_W2,
    DST_X2,
    DST_X3,
    DST_P1,
    DST_P2,
    DST_P3,
    DST_VN
  } dest_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    logic  half;
    dest_t dest;
  } uop_t;

  typedef struct packed {
    logic                load;
    logic                clear;
    logic                issue;
    logic [OP_IDX_W-1:0] step;
    logic                lane;
    logic                capture;
  } ctrl_cmd_t;

  function automatic uop_t uop_rom(input logic [OP_IDX_W-1:0] step);
    uop_t u;
    case (step)
      4'd0:    u = '{a: OPN_FRC, b: OPN_IM,  half: 1'b0, dest: DST_ACC};
      4'd1:    u = '{a: OPN_DT,  b: OPN_ACC, half: 1'b1, dest: DST_DV};
      4'd2:    u = '{a: OPN_DT,  b: OPN_VEL, half: 1'b0, dest: DST_T1};
      4'd3:    u = '{a: OPN_DT,  b: OPN_DV,  half: 1'b0, dest: DST_XN};
      4'd4:    u = '{a: OPN_W,   b: OPN_W,   half: 1'b0, dest: DST_W2};
      4'd5:    u = '{a: OPN_POS, b: OPN_POS, half: 1'b0, dest: DST_X2};
      4'd6:    u = '{a: OPN_X2,  b: OPN_POS, half: 1'b0, dest: DST_X3};
      4'd7:    u = '{a: OPN_W2,  b: OPN_POS, half: 1'b0, dest: DST_P1};
      4'd8:    u = '{a: OPN_C,   b: OPN_X2,  half: 1'b0, dest: DST_P2};
      4'd9:    u = '{a: OPN_G,   b: OPN_X3,  half: 1'b0, dest: DST_P3};
      4'd10:   u = '{a: OPN_FRC, b: OPN_IM,  half: 1'b0, dest: DST_ACC};
      4'd11:   u = '{a: OPN_DT,  b: OPN_ACC, half: 1'b1, dest: DST_VN};
      default: u = '{a: OPN_FRC, b: OPN_IM,  half: 1'b0, dest: DST_ACC};
    endcase
    return u;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > MAX32) || (v < MIN32);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > MAX32) begin
      r = MAX32[31:0];
    end else if (v < MIN32) begin
      r = MIN32[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/vva_ctrl.sv
`default_nettype none
module vva_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output vva_pkg::ctrl_cmd_t  ctl
);
  import vva_pkg::*;

  localparam logic [ISSUE_W-1:0] LAST_ISSUE = ISSUE_W'(2 * NUM_OPS - 1);

  ctrl_state_t        state, state_next;
  logic [ISSUE_W-1:0] cnt, cnt_next;
  logic               out_valid_next;
  logic               accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    accept      = 1'b0;
    ctl         = '0;
    ctl.step    = cnt[ISSUE_W-1:1];
    ctl.lane    = cnt[0];
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept) begin
          ctl.clear = 1'b1;
          cnt_next  = '0;
          if (cmd) begin
            state_next = ST_RUN;
          end else begin
            ctl.load   = 1'b1;
            state_next = ST_FINISH;
          end
        end
      end
      ST_RUN: begin
        ctl.issue = 1'b1;
        cnt_next  = cnt + ISSUE_W'(1);
        if (cnt == LAST_ISSUE) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          ctl.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = out_valid;
    if (ctl.capture) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/vva_datapath.sv
`default_nettype none
module vva_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vva_pkg::ctrl_cmd_t                  ctl,
  input  logic                                cfg_we,
  input  logic [vva_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic signed [31:0]                  load_pos_a,
  input  logic signed [31:0]                  load_pos_b,
  input  logic signed [31:0]                  load_vel_a,
  input  logic signed [31:0]                  load_vel_b,
  input  logic signed [31:0]                  load_force_a,
  input  logic signed [31:0]                  load_force_b,
  output logic signed [31:0]                  pos_a,
  output logic signed [31:0]                  pos_b,
  output logic signed [31:0]                  vel_a,
  output logic signed [31:0]                  vel_b,
  output logic signed [31:0]                  force_a,
  output logic signed [31:0]                  force_b,
  output logic                                saturated
);
  import vva_pkg::*;

  localparam logic signed [63:0] RND_FULL = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< FRAC_BITS;

  logic [30:0]        inv_mass;
  logic [30:0]        time_step;
  logic signed [31:0] harm_freq;
  logic signed [31:0] cubic;
  logic signed [31:0] quartic;

  logic signed [31:0] pos [2];
  logic signed [31:0] vel [2];
  logic signed [31:0] frc [2];
  logic signed [31:0] acc [2];
  logic signed [31:0] dv  [2];
  logic signed [31:0] vm  [2];
  logic signed [31:0] t1  [2];
  logic signed [31:0] w2  [2];
  logic signed [31:0] x2  [2];
  logic signed [31:0] x3  [2];
  logic signed [35:0] psum [2];
  logic               sat_flag;

  logic signed [63:0] prod;
  logic               wb_valid;
  dest_t              wb_dest;
  logic               wb_lane;
  logic               wb_half;

  uop_t               uop;
  logic signed [31:0] opa, opb, im_s, dt_s;

  logic signed [63:0] rsum, rs;
  logic signed [31:0] r;
  logic               r_ovf;
  logic signed [63:0] xn_sum, vm_sum, vn_sum;
  logic signed [35:0] p2_sum, p3_neg;
  logic               post_ovf;

  assign uop  = uop_rom(ctl.step);
  assign im_s = {1'b0, inv_mass};
  assign dt_s = {1'b0, time_step};

  always_comb begin
    case (uop.a)
      OPN_FRC: opa = frc[ctl.lane];
      OPN_DT:  opa = dt_s;
      OPN_W:   opa = harm_freq;
      OPN_POS: opa = pos[ctl.lane];
      OPN_X2:  opa = x2[ctl.lane];
      OPN_W2:  opa = w2[ctl.lane];
      OPN_C:   opa = cubic;
      OPN_G:   opa = quartic;
      default: opa = '0;
    endcase
    case (uop.b)
      OPN_IM:  opb = im_s;
      OPN_ACC: opb = acc[ctl.lane];
      OPN_VEL: opb = vel[ctl.lane];
      OPN_DV:  opb = dv[ctl.lane];
      OPN_W:   opb = harm_freq;
      OPN_POS: opb = pos[ctl.lane];
      OPN_X2:  opb = x2[ctl.lane];
      OPN_X3:  opb = x3[ctl.lane];
      default: opb = '0;
    endcase
  end

  always_comb begin
    rsum   = prod + (wb_half ? RND_HALF : RND_FULL);
    rs     = wb_half ? (rsum >>> (FRAC_BITS + 1)) : (rsum >>> FRAC_BITS);
    r      = clip32(rs);
    r_ovf  = ovf32(rs);
    xn_sum = 64'(pos[wb_lane]) + 64'(t1[wb_lane]) + 64'(r);
    vm_sum = 64'(vel[wb_lane]) + 64'(r);
    vn_sum = 64'(vm[wb_lane]) + 64'(r);
    p2_sum = psum[wb_lane] + 36'(r) + (36'(r) <<< 1);
    p3_neg = -(psum[wb_lane] + (36'(r) <<< 2));
    case (wb_dest)
      DST_DV:  post_ovf = ovf32(vm_sum);
      DST_XN:  post_ovf = ovf32(xn_sum);
      DST_P3:  post_ovf = ovf32(64'(p3_neg));
      DST_VN:  post_ovf = ovf32(vn_sum);
      default: post_ovf = 1'b0;
    endcase
  end

  // multiplier stage
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= ctl.issue;
    end
    prod    <= 64'(opa) * 64'(opb);
    wb_dest <= uop.dest;
    wb_lane <= ctl.lane;
    wb_half <= uop.half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mass  <= RST_INV_MASS;
      time_step <= RST_TIME_STEP;
      harm_freq <= RST_HARM_FREQ;
      cubic     <= RST_CUBIC;
      quartic   <= RST_QUARTIC;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_MASS:  inv_mass  <= cfg_data[30:0];
        CFG_TIME_STEP: time_step <= cfg_data[30:0];
        CFG_HARM_FREQ: harm_freq <= cfg_data;
        CFG_CUBIC:     cubic     <= cfg_data;
        CFG_QUARTIC:   quartic   <= cfg_data;
        default: ;
      endcase
    end
  end

  // write-back stage: load the lane registers, or round, saturate and retire into them
  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0]   <= '0;
      pos[1]   <= '0;
      vel[0]   <= '0;
      vel[1]   <= '0;
      frc[0]   <= '0;
      frc[1]   <= '0;
      sat_flag <= 1'b0;
    end else if (ctl.load) begin
      pos[0]   <= load_pos_a;
      pos[1]   <= load_pos_b;
      vel[0]   <= load_vel_a;
      vel[1]   <= load_vel_b;
      frc[0]   <= load_force_a;
      frc[1]   <= load_force_b;
      sat_flag <= 1'b0;
    end else if (ctl.clear) begin
      sat_flag <= 1'b0;
    end else if (wb_valid) begin
      sat_flag <= sat_flag | r_ovf | post_ovf;
      case (wb_dest)
        DST_ACC: acc[wb_lane] <= r;
        DST_DV: begin
          dv[wb_lane] <= r;
          vm[wb_lane] <= clip32(vm_sum);
        end
        DST_T1:  t1[wb_lane]   <= r;
        DST_XN:  pos[wb_lane]  <= clip32(xn_sum);
        DST_W2:  w2[wb_lane]   <= r;
        DST_X2:  x2[wb_lane]   <= r;
        DST_X3:  x3[wb_lane]   <= r;
        DST_P1:  psum[wb_lane] <= 36'(r);
        DST_P2:  psum[wb_lane] <= p2_sum;
        DST_P3:  frc[wb_lane]  <= clip32(64'(p3_neg));
        DST_VN:  vel[wb_lane]  <= clip32(vn_sum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      pos_a     <= pos[0];
      pos_b     <= pos[1];
      vel_a     <= vel[0];
      vel_b     <= vel[1];
      force_a   <= frc[0];
      force_b   <= frc[1];
      saturated <= sat_flag;
    end
  end

endmodule
`default_nettype wire

FILE: sv/velocity_verlet_anharmonic_step.sv
// Load word: loaded on accept; the finish state then captures the result.
// Step word: 24 products through one shared 32x32 multiplier, the two
// coordinates interleaved one per cycle, then a drain state for the last
// write-back and a finish state for the output; in_ready is low until capture.
// Reset (synchronous, rst high): state zero, registers to their reset values,
// no result pending.
`default_nettype none
module velocity_verlet_anharmonic_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic signed [31:0]            load_pos_a,
  input  logic signed [31:0]            load_pos_b,
  input  logic signed [31:0]            load_vel_a,
  input  logic signed [31:0]            load_vel_b,
  input  logic signed [31:0]            load_force_a,
  input  logic signed [31:0]            load_force_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            pos_a,
  output logic signed [31:0]            pos_b,
  output logic signed [31:0]            vel_a,
  output logic signed [31:0]            vel_b,
  output logic signed [31:0]            force_a,
  output logic signed [31:0]            force_b,
  output logic                          saturated,
  input  logic                          cfg_we,
  input  logic [vva_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import vva_pkg::*;

  ctrl_cmd_t ctl;

  vva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  vva_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .load_pos_a   (load_pos_a),
    .load_pos_b   (load_pos_b),
    .load_vel_a   (load_vel_a),
    .load_vel_b   (load_vel_b),
    .load_force_a (load_force_a),
    .load_force_b (load_force_b),
    .pos_a        (pos_a),
    .pos_b        (pos_b),
    .vel_a        (vel_a),
    .vel_b        (vel_b),
    .force_a      (force_a),
    .force_b      (force_b),
    .saturated    (saturated)
  );

endmodule
`default_nettype wire

FILE: tb/tb_velocity_verlet_anharmonic_step.sv
`timescale 1ns / 100ps
module tb_velocity_verlet_anharmonic_step;
  import vva_pkg::*;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 250;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 400;
  localparam bit CMD_LOAD = 1'b0;
  localparam bit CMD_STEP = 1'b1;
  localparam logic signed [31:0] TOP = 32'sh7fffffff;
  localparam logic signed [31:0] BOT = 32'sh80000000;
  localparam logic signed [31:0] ONES = 32'shffffffff;
  localparam logic signed [31:0] ODD_BITS = 32'sh55555555;
  localparam logic signed [31:0] EVEN_BITS = 32'shaaaaaaaa;
  localparam logic signed [31:0] UNIT = 32'sd65536;
  localparam logic signed [63:0] HI64 = 64'sd2147483647;
  localparam logic signed [63:0] LO64 = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_a;
    logic signed [31:0] pos_b;
    logic signed [31:0] vel_a;
    logic signed [31:0] vel_b;
    logic signed [31:0] force_a;
    logic signed [31:0] force_b;
    logic               saturated;
  } state_word_t;

  typedef struct packed {
    logic               cmd_bit;
    logic signed [31:0] p_a;
    logic signed [31:0] p_b;
    logic signed [31:0] v_a;
    logic signed [31:0] v_b;
    logic signed [31:0] f_a;
    logic signed [31:0] f_b;
    logic               typed;
    state_word_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic signed [31:0] load_pos_a = '0;
  logic signed [31:0] load_pos_b = '0;
  logic signed [31:0] load_vel_a = '0;
  logic signed [31:0] load_vel_b = '0;
  logic signed [31:0] load_force_a = '0;
  logic signed [31:0] load_force_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] pos_a, pos_b, vel_a, vel_b, force_a, force_b;
  logic saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of state and registers
  logic signed [31:0] lane_pos [2];
  logic signed [31:0] lane_vel [2];
  logic signed [31:0] lane_frc [2];
  logic [30:0] inv_mass_m, dt_m;
  logic signed [31:0] w_m, c_m, g_m;
  bit clip_seen;

  state_word_t state_words_due [$];
  stim_row_t directed_rows [$];
  int words_checked = 0;
  int bad_words = 0;
  bit quiet = 1'b0;

  velocity_verlet_anharmonic_step #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] clip(input logic signed [63:0] v);
    if (v > HI64) begin
      clip_seen = 1'b1;
      return TOP;
    end
    if (v < LO64) begin
      clip_seen = 1'b1;
      return BOT;
    end
    return v[31:0];
  endfunction

  // product, shifted right by s with rounding half up, then clipped
  function automatic logic signed [31:0] fx_mul(input logic signed [63:0] p,
                                                input logic signed [63:0] q,
                                                input int s);
    logic signed [63:0] prod;
    prod = p * q + (64'sd1 <<< (s - 1));
    return clip(prod >>> s);
  endfunction

  function automatic void advance_lane(input int k);
    logic signed [63:0] x, v, f, acc, dv, t1, t2, xn, vm, w2, x2, x3;
    logic signed [63:0] p1, p2, p3, sum, fn, acc2, kick;
    x = lane_pos[k];
    v = lane_vel[k];
    f = lane_frc[k];
    acc = fx_mul(f, inv_mass_m, FRAC);
    dv = fx_mul(dt_m, acc, FRAC + 1);
    t1 = fx_mul(dt_m, v, FRAC);
    t2 = fx_mul(dt_m, dv, FRAC);
    xn = clip(x + t1 + t2);
    vm = clip(v + dv);
    w2 = fx_mul(w_m, w_m, FRAC);
    x2 = fx_mul(xn, xn, FRAC);
    x3 = fx_mul(x2, xn, FRAC);
    p1 = fx_mul(w2, xn, FRAC);
    p2 = fx_mul(c_m, x2, FRAC);
    p3 = fx_mul(g_m, x3, FRAC);
    sum = p1 + 64'sd3 * p2 + 64'sd4 * p3;
    fn = clip(-sum);
    acc2 = fx_mul(fn, inv_mass_m, FRAC);
    kick = fx_mul(dt_m, acc2, FRAC + 1);
    lane_pos[k] = xn[31:0];
    lane_vel[k] = clip(vm + kick);
    lane_frc[k] = fn[31:0];
  endfunction

  function automatic state_word_t integrate_word(input stim_row_t r);
    clip_seen = 1'b0;
    if (r.cmd_bit == CMD_LOAD) begin
      lane_pos[0] = r.p_a;
      lane_pos[1] = r.p_b;
      lane_vel[0] = r.v_a;
      lane_vel[1] = r.v_b;
      lane_frc[0] = r.f_a;
      lane_frc[1] = r.f_b;
    end else begin
      advance_lane(0);
      advance_lane(1);
    end
    return {lane_pos[0], lane_pos[1], lane_vel[0], lane_vel[1],
            lane_frc[0], lane_frc[1], clip_seen};
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1, 2: return 32'($urandom_range(0, 262144)) - 32'd131072;
      3, 4:    return 32'($urandom_range(0, 16777216)) - 32'd8388608;
      5:       return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       return TOP;
          1:       return BOT;
          2:       return '0;
          default: return ONES;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] small_coef();
    return 32'($urandom_range(0, 8192)) - 32'd4096;
  endfunction

  task automatic add_row(input bit c, input logic signed [31:0] pa, pb, va, vb,
                         fa, fb, input bit typed, input state_word_t want);
    stim_row_t r;
    r = {c, pa, pb, va, vb, fa, fb, typed, want};
    directed_rows.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_INV_MASS:  inv_mass_m = data[30:0];
      CFG_TIME_STEP: dt_m = data[30:0];
      CFG_HARM_FREQ: w_m = data;
      CFG_CUBIC:     c_m = data;
      CFG_QUARTIC:   g_m = data;
      default: ;
    endcase
  endtask

  task automatic send_word(input stim_row_t r);
    state_word_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= r.cmd_bit;
    load_pos_a <= r.p_a;
    load_pos_b <= r.p_b;
    load_vel_a <= r.v_a;
    load_vel_b <= r.v_b;
    load_force_a <= r.f_a;
    load_force_b <= r.f_b;
    predicted = integrate_word(r);
    state_words_due.push_back(r.typed ? r.want : predicted);
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (state_words_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic flag_word(input string why, input state_word_t want,
                           input state_word_t got);
    bad_words++;
    if (bad_words <= 10) begin
      $display("%0t %s: want pos %0d %0d vel %0d %0d force %0d %0d sat %0b",
               $time, why, want.pos_a, want.pos_b, want.vel_a, want.vel_b,
               want.force_a, want.force_b, want.saturated);
      $display("    got pos %0d %0d vel %0d %0d force %0d %0d sat %0b",
               got.pos_a, got.pos_b, got.vel_a, got.vel_b,
               got.force_a, got.force_b, got.saturated);
    end
  endtask

  // result side: random stalls, one long hold-off, checking
  initial begin : sink
    int idle_left;
    int hold_left;
    bit hold_done;
    state_word_t got;
    state_word_t want;
    idle_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = {pos_a, pos_b, vel_a, vel_b, force_a, force_b, saturated};
        words_checked++;
        if (state_words_due.size() == 0) begin
          flag_word("word with none due", '0, got);
        end else begin
          want = state_words_due.pop_front();
          if (got !== want) flag_word("state word mismatch", want, got);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && words_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main
    stim_row_t row;
    int ph;
    int n;
    inv_mass_m = 31'd65536;
    dt_m = 31'd655;
    w_m = UNIT;
    c_m = '0;
    g_m = '0;
    for (n = 0; n < 2; n++) begin
      lane_pos[n] = '0;
      lane_vel[n] = '0;
      lane_frc[n] = '0;
    end

    // zero state stays at rest
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b1, {32'sd0, 32'sd0, 32'sd0, 32'sd0,
            32'sd0, 32'sd0, 1'b0});
    add_row(CMD_LOAD, UNIT, -UNIT, 32768, -32768, 0, 0, 1'b1,
            {UNIT, -UNIT, 32'sd32768, -32'sd32768, 32'sd0, 32'sd0, 1'b0});
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    // load fields ignored on a step
    add_row(CMD_STEP, ONES, ONES, ONES, ONES, ONES, ONES, 1'b0, '0);
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_LOAD, TOP, BOT, BOT, TOP, TOP, BOT, 1'b1,
            {TOP, BOT, BOT, TOP, TOP, BOT, 1'b0});
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_LOAD, BOT, TOP, TOP, BOT, BOT, TOP, 1'b1,
            {BOT, TOP, TOP, BOT, BOT, TOP, 1'b0});
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_LOAD, 0, 0, 0, 0, 0, 0, 1'b1, {32'sd0, 32'sd0, 32'sd0, 32'sd0,
            32'sd0, 32'sd0, 1'b0});
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b1, {32'sd0, 32'sd0, 32'sd0, 32'sd0,
            32'sd0, 32'sd0, 1'b0});
    add_row(CMD_LOAD, ONES, ONES, ONES, ONES, ONES, ONES, 1'b1,
            {ONES, ONES, ONES, ONES, ONES, ONES, 1'b0});
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_LOAD, ODD_BITS, EVEN_BITS, ODD_BITS, EVEN_BITS, ODD_BITS,
            EVEN_BITS, 1'b1, {ODD_BITS, EVEN_BITS, ODD_BITS, EVEN_BITS,
            ODD_BITS, EVEN_BITS, 1'b0});
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_LOAD, 3 * UNIT, -2 * UNIT, 0, 0, 100 * UNIT, -100 * UNIT, 1'b1,
            {3 * UNIT, -2 * UNIT, 32'sd0, 32'sd0, 100 * UNIT, -100 * UNIT, 1'b0});
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (directed_rows.size() != 0) send_word(directed_rows.pop_front());

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle(4);
      case (ph)
        1: begin
          // zero inverse mass: no acceleration
          write_reg(CFG_INV_MASS, 32'd0);
          write_reg(CFG_TIME_STEP, $urandom_range(0, 65536));
          write_reg(CFG_HARM_FREQ, $urandom);
          write_reg(CFG_CUBIC, $urandom);
          write_reg(CFG_QUARTIC, $urandom);
        end
        2: begin
          // bit 31 of the unsigned registers is dropped
          write_reg(CFG_INV_MASS, 32'hffffffff);
          write_reg(CFG_TIME_STEP, 32'hffffffff);
          write_reg(CFG_HARM_FREQ, TOP);
          write_reg(CFG_CUBIC, TOP);
          write_reg(CFG_QUARTIC, TOP);
        end
        3: begin
          write_reg(CFG_INV_MASS, 32'd1);
          write_reg(CFG_TIME_STEP, 32'd0);
          write_reg(CFG_HARM_FREQ, BOT);
          write_reg(CFG_CUBIC, BOT);
          write_reg(CFG_QUARTIC, BOT);
        end
        4, 6: begin
          write_reg(CFG_INV_MASS, $urandom);
          write_reg(CFG_TIME_STEP, $urandom);
          write_reg(CFG_HARM_FREQ, $urandom);
          write_reg(CFG_CUBIC, $urandom);
          write_reg(CFG_QUARTIC, $urandom);
        end
        5: begin
          write_reg(CFG_INV_MASS, $urandom_range(4096, 1 << 20));
          write_reg(CFG_TIME_STEP, $urandom_range(0, 4096));
          write_reg(CFG_HARM_FREQ, 32'($urandom_range(0, 1 << 19)) - 32'd262144);
          write_reg(CFG_CUBIC, small_coef());
          write_reg(CFG_QUARTIC, small_coef());
        end
        default: begin
          write_reg(CFG_INV_MASS, 32'd65536);
          write_reg(CFG_TIME_STEP, 32'd655);
          write_reg(CFG_HARM_FREQ, 32'($urandom_range(32768, 131072)));
          write_reg(CFG_CUBIC, small_coef());
          write_reg(CFG_QUARTIC, small_coef());
        end
      endcase
      // unmapped index, must not disturb anything
      write_reg(CFG_QUARTIC + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
      cfg_we <= 1'b0;
      quiet = (ph == PHASES - 1);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        row.cmd_bit = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_STEP;
        row.p_a = pick_value();
        row.p_b = pick_value();
        row.v_a = pick_value();
        row.v_b = pick_value();
        row.f_a = pick_value();
        row.f_b = pick_value();
        row.typed = 1'b0;
        row.want = '0;
        send_word(row);
      end
    end

    wait_idle(40);
    bad_words += state_words_due.size();
    if (bad_words == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
